// File: rtl/assert_macros.svh
// assertion macros shared by the beam stiffness assembly rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bsa assertion failed");

// next-cycle implication, checked out of reset
`define BSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bsa assertion failed");

`endif

// File: rtl/bsa_pkg.sv
// types, codes and constants of the beam stiffness assembly
package bsa_pkg;

  localparam int NODE_COUNT_DEF = 64;

  // wide arithmetic for the coefficient unit
  localparam int LIMBS  = 6;
  localparam int LIMB_W = 32;
  localparam int WIDE_W = LIMBS * LIMB_W;
  localparam int REM_W  = 101;
  localparam int MAG_W  = 63;

  typedef logic [LIMBS-1:0][LIMB_W-1:0] wide_t;
  typedef logic [MAG_W-1:0]             mag_t;

  // operation codes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CON   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LEN   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_MODULUS = 2'd2;
  localparam logic [1:0] REG_PENALTY = 2'd3;

  // element coefficient kinds
  localparam logic [1:0] KIND_A = 2'd0;
  localparam logic [1:0] KIND_B = 2'd1;
  localparam logic [1:0] KIND_D = 2'd2;
  localparam logic [1:0] KIND_F = 2'd3;

  typedef enum logic [3:0] {
    TS_CLEAR, TS_IDLE, TS_START, TS_COEF, TS_ACC_RD, TS_ACC_WR,
    TS_CON, TS_RD, TS_RDV, TS_DONE
  } top_state_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_BASE, CS_LOAD, CS_DEN, CS_MUL, CS_DIV, CS_DONE
  } coef_state_t;

  typedef struct packed {
    mag_t a;
    mag_t b;
    mag_t d;
    mag_t f;
    logic sat;
  } coef_res_t;

  // multiplier of coefficient k: 12, 6, 4, 2
  function automatic logic [31:0] coef_mult(input logic [1:0] k);
    logic [31:0] m;
    case (k)
      2'd0:    m = 32'd12;
      2'd1:    m = 32'd6;
      2'd2:    m = 32'd4;
      default: m = 32'd2;
    endcase
    return m;
  endfunction

  // power of the length in the denominator of coefficient k
  function automatic logic [1:0] coef_pow(input logic [1:0] k);
    logic [1:0] p;
    case (k)
      2'd0:    p = 2'd3;
      2'd1:    p = 2'd2;
      default: p = 2'd1;
    endcase
    return p;
  endfunction

  // which coefficient sits at element entry e (row-major)
  function automatic logic [1:0] elem_kind(input logic [3:0] e);
    logic [1:0] kd;
    case (e)
      4'd0, 4'd2, 4'd8, 4'd10: kd = KIND_A;
      4'd5, 4'd15:             kd = KIND_D;
      4'd7, 4'd13:             kd = KIND_F;
      default:                 kd = KIND_B;
    endcase
    return kd;
  endfunction

  // negated element entries
  function automatic logic elem_neg(input logic [3:0] e);
    logic n;
    case (e)
      4'd2, 4'd6, 4'd8, 4'd9, 4'd11, 4'd14: n = 1'b1;
      default:                              n = 1'b0;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/bsa_in_if.sv
// input channel of the beam stiffness assembly
interface bsa_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [6:0]         left_node;
  logic [6:0]         right_node;
  logic signed [31:0] left_position;
  logic signed [31:0] right_position;
  logic [7:0]         dof_number;
  logic [6:0]         read_row;
  logic [6:0]         read_col;

  modport source (
    output valid, op, left_node, right_node, left_position, right_position,
           dof_number, read_row, read_col,
    input  ready
  );
  modport sink (
    input  valid, op, left_node, right_node, left_position, right_position,
           dof_number, read_row, read_col,
    output ready
  );
endinterface

// File: rtl/bsa_out_if.sv
// result channel of the beam stiffness assembly
interface bsa_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [63:0] entry_value;
  logic               saturated;

  modport source (output valid, status, entry_value, saturated, input ready);
  modport sink   (input valid, status, entry_value, saturated, output ready);
endinterface

// File: rtl/bsa_cfg_if.sv
// configuration write channel of the beam stiffness assembly
interface bsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/beam_stiffness_assembly.sv
// Beam stiffness assembly: keeps a (2*NODE_COUNT)^2 Q48.16 global stiffness
// matrix in one single-port memory and answers every transaction with one
// result. After reset a clearing pass writes zero to every entry, one per
// cycle; input is held off meanwhile but configuration writes are taken.
// A clear transaction runs the same pass. In an add-element transaction
// the coefficient unit forms E*w*h^3 with a shared 32x32 limb multiplier,
// then each coefficient (with 192 one-bit division steps), then 16
// read-modify-write accumulations run through the memory port. Items are
// handled one at a time; the result register lets a new transaction start
// while the last result waits to be taken.
`include "assert_macros.svh"

module beam_stiffness_assembly #(
  parameter int NODE_COUNT = bsa_pkg::NODE_COUNT_DEF
) (
  input logic       clk,
  input logic       rst_n,
  bsa_in_if.sink    in_if,
  bsa_out_if.source out_if,
  bsa_cfg_if.sink   cfg_if
);

  localparam int DOF   = 2 * NODE_COUNT;
  localparam int NW    = $clog2(NODE_COUNT);
  localparam int RW    = $clog2(DOF);
  localparam int DEPTH = DOF * DOF;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 10;

  bsa_pkg::top_state_t state_r, state_nxt;

  logic [31:0] width_r, height_r, emod_r, len_r;
  logic [62:0] pen_r;
  logic [NW-1:0] ln_m1_r, rn_m1_r;
  logic [RW-1:0] con_row_r, rd_row_r, rd_col_r;
  logic          clr_op_r;
  logic [AW-1:0] clr_r;
  logic [3:0]    e_r;
  logic [1:0]    status_r, status_nxt;
  logic signed [63:0] value_r;
  logic          sat_r;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [63:0] out_value_r;
  logic               out_sat_r;

  logic [63:0] stiff_mem [DEPTH];
  logic [63:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [63:0]   mem_wdata;

  logic               coef_start, coef_done;
  bsa_pkg::coef_res_t coef_res;

  logic        accept, out_free, ln_ok, rn_ok, len_ok, dof_ok, rd_ok;
  logic [32:0] len33;
  logic [RW-1:0] acc_row, acc_col;
  logic [62:0] mag;
  logic [63:0] vterm;
  logic [64:0] sum65;
  logic        acc_ovf;
  logic [63:0] acc_val;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [RW-1:0] c);
    return AW'(r) * AW'(DOF) + AW'(c);
  endfunction

  bsa_coef u_coef (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (coef_start),
    .e_mod    (emod_r),
    .b_width  (width_r),
    .b_height (height_r),
    .len      (len_r),
    .done     (coef_done),
    .res      (coef_res)
  );

  // transaction decode and range checks
  always_comb begin
    accept   = in_if.valid && in_if.ready;
    out_free = !out_valid_r || out_if.ready;
    ln_ok    = (in_if.left_node != 7'd0) && (CW'(in_if.left_node) <= CW'(NODE_COUNT));
    rn_ok    = (in_if.right_node != 7'd0) && (CW'(in_if.right_node) <= CW'(NODE_COUNT));
    len33    = {in_if.right_position[31], in_if.right_position}
             - {in_if.left_position[31], in_if.left_position};
    len_ok   = !len33[32] && (len33 != 33'd0);
    dof_ok   = (in_if.dof_number != 8'd0) && (CW'(in_if.dof_number) <= CW'(DOF));
    rd_ok    = (CW'(in_if.read_row) < CW'(DOF)) && (CW'(in_if.read_col) < CW'(DOF));
    status_nxt = bsa_pkg::ST_OK;
    case (in_if.op)
      bsa_pkg::OP_ADD: begin
        if (!(ln_ok && rn_ok)) status_nxt = bsa_pkg::ST_RANGE;
        else if (!len_ok) status_nxt = bsa_pkg::ST_LEN;
      end
      bsa_pkg::OP_CON:  if (!dof_ok) status_nxt = bsa_pkg::ST_RANGE;
      bsa_pkg::OP_READ: if (!rd_ok) status_nxt = bsa_pkg::ST_RANGE;
      default: ;
    endcase
  end

  // element entry and saturating accumulation
  always_comb begin
    acc_row = {(e_r[3] ? rn_m1_r : ln_m1_r), e_r[2]};
    acc_col = {(e_r[1] ? rn_m1_r : ln_m1_r), e_r[0]};
    case (bsa_pkg::elem_kind(e_r))
      bsa_pkg::KIND_A: mag = coef_res.a;
      bsa_pkg::KIND_B: mag = coef_res.b;
      bsa_pkg::KIND_D: mag = coef_res.d;
      default:         mag = coef_res.f;
    endcase
    vterm   = bsa_pkg::elem_neg(e_r) ? -{1'b0, mag} : {1'b0, mag};
    sum65   = {rd_data_r[63], rd_data_r} + {vterm[63], vterm};
    acc_ovf = sum65[64] ^ sum65[63];
    if (acc_ovf) acc_val = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else acc_val = sum65[63:0];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsa_pkg::TS_CLEAR: begin
        if (clr_r == AW'(DEPTH - 1)) state_nxt = clr_op_r ? bsa_pkg::TS_DONE : bsa_pkg::TS_IDLE;
      end
      bsa_pkg::TS_IDLE: begin
        if (accept) begin
          case (in_if.op)
            bsa_pkg::OP_ADD: begin
              state_nxt = (ln_ok && rn_ok && len_ok) ? bsa_pkg::TS_START : bsa_pkg::TS_DONE;
            end
            bsa_pkg::OP_CON:  state_nxt = dof_ok ? bsa_pkg::TS_CON : bsa_pkg::TS_DONE;
            bsa_pkg::OP_READ: state_nxt = rd_ok ? bsa_pkg::TS_RD : bsa_pkg::TS_DONE;
            default:          state_nxt = bsa_pkg::TS_CLEAR;
          endcase
        end
      end
      bsa_pkg::TS_START:  state_nxt = bsa_pkg::TS_COEF;
      bsa_pkg::TS_COEF:   if (coef_done) state_nxt = bsa_pkg::TS_ACC_RD;
      bsa_pkg::TS_ACC_RD: state_nxt = bsa_pkg::TS_ACC_WR;
      bsa_pkg::TS_ACC_WR: begin
        state_nxt = (e_r == 4'd15) ? bsa_pkg::TS_DONE : bsa_pkg::TS_ACC_RD;
      end
      bsa_pkg::TS_CON:    state_nxt = bsa_pkg::TS_DONE;
      bsa_pkg::TS_RD:     state_nxt = bsa_pkg::TS_RDV;
      bsa_pkg::TS_RDV:    state_nxt = bsa_pkg::TS_DONE;
      bsa_pkg::TS_DONE:   if (out_free) state_nxt = bsa_pkg::TS_IDLE;
      default:            state_nxt = bsa_pkg::TS_CLEAR;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_if.ready  = (state_r == bsa_pkg::TS_IDLE);
    coef_start   = (state_r == bsa_pkg::TS_START);
    mem_we       = 1'b0;
    mem_wdata    = '0;
    mem_addr     = addr_of(acc_row, acc_col);
    case (state_r)
      bsa_pkg::TS_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
      end
      bsa_pkg::TS_ACC_WR: begin
        mem_we    = 1'b1;
        mem_wdata = acc_val;
      end
      bsa_pkg::TS_CON: begin
        mem_we    = 1'b1;
        mem_addr  = addr_of(con_row_r, con_row_r);
        mem_wdata = {1'b0, pen_r};
      end
      bsa_pkg::TS_RD:  mem_addr = addr_of(rd_row_r, rd_col_r);
      default: ;
    endcase
  end

  assign cfg_if.ready      = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.entry_value = out_value_r;
  assign out_if.saturated  = out_sat_r;

  // matrix memory
  always_ff @(posedge clk) begin
    if (mem_we) stiff_mem[mem_addr] <= mem_wdata;
    rd_data_r <= stiff_mem[mem_addr];
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsa_pkg::TS_CLEAR;
      clr_r       <= '0;
      clr_op_r    <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= 32'd65536;
      height_r    <= 32'd65536;
      emod_r      <= 32'd1;
      pen_r       <= '1;
    end else begin
      state_r <= state_nxt;
      if (state_r == bsa_pkg::TS_CLEAR) begin
        clr_r <= (clr_r == AW'(DEPTH - 1)) ? '0 : clr_r + AW'(1);
      end
      if (accept) clr_op_r <= (in_if.op == bsa_pkg::OP_CLEAR);
      if (state_r == bsa_pkg::TS_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
      if (cfg_if.valid) begin
        case (cfg_if.index)
          bsa_pkg::REG_WIDTH:   width_r  <= cfg_if.data[31:0];
          bsa_pkg::REG_HEIGHT:  height_r <= cfg_if.data[31:0];
          bsa_pkg::REG_MODULUS: emod_r   <= cfg_if.data[31:0];
          bsa_pkg::REG_PENALTY: pen_r    <= cfg_if.data[62:0];
          default: ;
        endcase
      end
    end
  end

  // transaction payload and result
  always_ff @(posedge clk) begin
    if (accept) begin
      ln_m1_r   <= NW'(CW'(in_if.left_node) - CW'(1));
      rn_m1_r   <= NW'(CW'(in_if.right_node) - CW'(1));
      len_r     <= len33[31:0];
      con_row_r <= RW'(CW'(in_if.dof_number) - CW'(1));
      rd_row_r  <= RW'(in_if.read_row);
      rd_col_r  <= RW'(in_if.read_col);
      value_r   <= '0;
      sat_r     <= 1'b0;
      e_r       <= 4'd0;
      status_r  <= status_nxt;
    end
    if (state_r == bsa_pkg::TS_COEF && coef_done && coef_res.sat) sat_r <= 1'b1;
    if (state_r == bsa_pkg::TS_ACC_WR) begin
      if (acc_ovf) sat_r <= 1'b1;
      e_r <= e_r + 4'd1;
    end
    if (state_r == bsa_pkg::TS_RDV) value_r <= rd_data_r;
    if (state_r == bsa_pkg::TS_DONE && out_free) begin
      out_status_r <= status_r;
      out_value_r  <= value_r;
      out_sat_r    <= sat_r;
    end
  end

  `BSA_ASSERT_NXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready)
  `BSA_ASSERT_IMP(a_no_write_idle, state_r == bsa_pkg::TS_IDLE, !mem_we)
  `BSA_ASSERT_IMP(a_result_from_done, $rose(out_valid_r), $past(state_r == bsa_pkg::TS_DONE))
  `BSA_ASSERT_IMP(a_value_only_ok, out_if.valid && (out_if.status != bsa_pkg::ST_OK), out_if.entry_value == 64'sd0)

endmodule

// File: rtl/bsa_coef.sv
// element coefficient unit: limb-serial multiplier and bit-serial divider
module bsa_coef (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        e_mod,
  input  logic [31:0]        b_width,
  input  logic [31:0]        b_height,
  input  logic [31:0]        len,
  output logic               done,
  output bsa_pkg::coef_res_t res
);

  localparam logic [1:0] TGT_BASE = 2'd0;
  localparam logic [1:0] TGT_NUM  = 2'd1;
  localparam logic [1:0] TGT_DEN  = 2'd2;

  bsa_pkg::coef_state_t state_r, state_nxt, ret_r;
  logic [1:0]           tgt_r;
  logic [31:0]          mul_m_r;
  logic [31:0]          carry_r;
  logic [2:0]           li_r;
  logic [2:0]           j_r;
  logic [1:0]           k_r;
  logic [7:0]           bit_r;
  bsa_pkg::wide_t       base_r, num_r, den_r;
  logic [bsa_pkg::WIDE_W-1:0] num_flat, den_flat;
  logic [bsa_pkg::REM_W-2:0]  rem_r;
  logic [bsa_pkg::REM_W-1:0]  rem_sh, rem_new;
  bsa_pkg::mag_t        quo_r, quo_cur;
  logic                 ovf_r, ovf_cur, ge;
  bsa_pkg::coef_res_t   res_r;
  logic [31:0]          limb_in, base_op;
  logic [63:0]          prod;

  // shared 32x32 limb multiplier with carry in
  always_comb begin
    case (tgt_r)
      TGT_BASE: limb_in = base_r[li_r];
      TGT_NUM:  limb_in = num_r[li_r];
      default:  limb_in = den_r[li_r];
    endcase
    prod = 64'(limb_in) * 64'(mul_m_r) + 64'(carry_r);
  end

  // operand of the base product E*w*h*h*h
  always_comb begin
    case (j_r)
      3'd0:    base_op = e_mod;
      3'd1:    base_op = b_width;
      default: base_op = b_height;
    endcase
  end

  // one restoring division step
  always_comb begin
    num_flat = num_r;
    den_flat = den_r;
    rem_sh   = {rem_r, num_flat[bit_r]};
    ge       = rem_sh >= den_flat[bsa_pkg::REM_W-1:0];
    rem_new  = ge ? rem_sh - den_flat[bsa_pkg::REM_W-1:0] : rem_sh;
    quo_cur  = quo_r;
    ovf_cur  = ovf_r;
    if (ge) begin
      if (bit_r >= 8'(bsa_pkg::MAG_W)) ovf_cur = 1'b1;
      else quo_cur[bit_r[5:0]] = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bsa_pkg::CS_IDLE: if (start) state_nxt = bsa_pkg::CS_BASE;
      bsa_pkg::CS_BASE: state_nxt = (j_r == 3'd5) ? bsa_pkg::CS_LOAD : bsa_pkg::CS_MUL;
      bsa_pkg::CS_LOAD: state_nxt = bsa_pkg::CS_MUL;
      bsa_pkg::CS_MUL:  if (li_r == 3'd5) state_nxt = ret_r;
      bsa_pkg::CS_DEN:  state_nxt = (j_r == 3'd3) ? bsa_pkg::CS_DIV : bsa_pkg::CS_MUL;
      bsa_pkg::CS_DIV: begin
        if (bit_r == 8'd0) state_nxt = (k_r == 2'd3) ? bsa_pkg::CS_DONE : bsa_pkg::CS_LOAD;
      end
      bsa_pkg::CS_DONE: state_nxt = bsa_pkg::CS_IDLE;
      default:          state_nxt = bsa_pkg::CS_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done = (state_r == bsa_pkg::CS_DONE);
    res  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bsa_pkg::CS_IDLE;
    else state_r <= state_nxt;
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      bsa_pkg::CS_IDLE: begin
        if (start) begin
          base_r    <= bsa_pkg::wide_t'(1);
          j_r       <= 3'd0;
          res_r.sat <= 1'b0;
        end
      end
      bsa_pkg::CS_BASE: begin
        if (j_r == 3'd5) begin
          k_r <= 2'd0;
        end else begin
          tgt_r   <= TGT_BASE;
          mul_m_r <= base_op;
          j_r     <= j_r + 3'd1;
          li_r    <= 3'd0;
          carry_r <= '0;
          ret_r   <= bsa_pkg::CS_BASE;
        end
      end
      bsa_pkg::CS_LOAD: begin
        num_r   <= base_r;
        den_r   <= bsa_pkg::wide_t'(12);
        tgt_r   <= TGT_NUM;
        mul_m_r <= bsa_pkg::coef_mult(k_r);
        li_r    <= 3'd0;
        carry_r <= '0;
        j_r     <= 3'd0;
        ret_r   <= bsa_pkg::CS_DEN;
      end
      bsa_pkg::CS_DEN: begin
        if (j_r == 3'd3) begin
          rem_r <= '0;
          quo_r <= '0;
          ovf_r <= 1'b0;
          bit_r <= 8'(bsa_pkg::WIDE_W - 1);
        end else begin
          tgt_r   <= TGT_DEN;
          mul_m_r <= (j_r < {1'b0, bsa_pkg::coef_pow(k_r)}) ? len : 32'd65536;
          j_r     <= j_r + 3'd1;
          li_r    <= 3'd0;
          carry_r <= '0;
          ret_r   <= bsa_pkg::CS_DEN;
        end
      end
      bsa_pkg::CS_MUL: begin
        case (tgt_r)
          TGT_BASE: base_r[li_r] <= prod[31:0];
          TGT_NUM:  num_r[li_r]  <= prod[31:0];
          default:  den_r[li_r]  <= prod[31:0];
        endcase
        carry_r <= prod[63:32];
        li_r    <= li_r + 3'd1;
      end
      bsa_pkg::CS_DIV: begin
        rem_r <= rem_new[bsa_pkg::REM_W-2:0];
        quo_r <= quo_cur;
        ovf_r <= ovf_cur;
        bit_r <= bit_r - 8'd1;
        if (bit_r == 8'd0) begin
          // saturate the magnitude and file it under its coefficient
          case (k_r)
            2'd0:    res_r.a <= ovf_cur ? '1 : quo_cur;
            2'd1:    res_r.b <= ovf_cur ? '1 : quo_cur;
            2'd2:    res_r.d <= ovf_cur ? '1 : quo_cur;
            default: res_r.f <= ovf_cur ? '1 : quo_cur;
          endcase
          if (ovf_cur) res_r.sat <= 1'b1;
          k_r <= k_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule
